@@ hw/rtl/fra_pkg.sv @@
package fra_pkg;

   // Width of one stored value and of a result value.
   localparam int unsigned DATA_W = 32;

   // Request opcodes as carried in the mode field of a request beat.
   typedef enum logic [1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_QUERY = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   // Status codes returned with every response beat.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Value returned by a pop or an average query on an empty queue.
   localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

endpackage

@@ hw/rtl/fra_ram.sv @@
module fra_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

@@ hw/rtl/fifo_running_average_top.sv @@
// Push, an empty pop or query, and an unused mode: result beat valid the cycle after acceptance.
// Pop with data: the memory read is registered, then ST_POP and ST_RESP load the result beat.
// Query with data: the quotient comes from the bit-serial divider in ST_DIV, which produces one
// quotient bit per cycle, and is then loaded into the result beat in ST_RESP.
// One request at a time; the next is taken once the result is registered and the output is free.
// Reset clears the indices, the item count and the running sum; the entry memory is not cleared.
module fifo_running_average_top
   import fra_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_result_value,
   output logic [1:0]               rsp_status
);

   localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W   = DATA_W + IDX_W;
   localparam int unsigned STEP_W  = $clog2(SUM_W);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_DIV,
      ST_RESP
   } state_type;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      head_ff, head_in;
   logic [IDX_W-1:0]      tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]     out_value_ff, out_value_in;
   status_type            out_status_ff, out_status_in;
   logic [DATA_W-1:0]     res_value_ff, res_value_in;
   logic [SUM_W-1:0]      div_num_ff, div_num_in;
   logic [CNT_W-1:0]      div_rem_ff, div_rem_in;
   logic [STEP_W-1:0]     div_step_ff, div_step_in;
   logic                  div_neg_ff, div_neg_in;

   logic                  out_free;
   logic                  req_beat;
   mode_type              mode;
   logic                  is_empty;
   logic                  is_full;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [DATA_W-1:0]     ram_rd_data;
   logic [CNT_W:0]        rem_shift;
   logic                  rem_ge;
   logic [SUM_W-1:0]      quot_signed;

   // The output register may be reloaded when it is empty or being drained this cycle.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_beat  = req_valid && !req_stall;
   assign mode      = mode_type'(req_mode);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == FULL_CNT);

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_value = out_value_ff;
   assign rsp_status       = out_status_ff;

   // Memory access: pushes write at the tail, pops read at the head.
   assign ram_wr_en = req_beat && (mode == MODE_PUSH) && !is_full;
   assign ram_rd_en = req_beat && (mode == MODE_POP) && !is_empty;

   fra_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (req_value),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   // One restoring division step on the remainder and the next dividend bit.
   assign rem_shift   = {div_rem_ff, div_num_ff[SUM_W-1]};
   assign rem_ge      = (rem_shift >= {1'b0, count_ff});
   assign quot_signed = div_neg_ff ? (SUM_W'(0) - div_num_ff) : div_num_ff;

   // Next-state logic for the controller and the queue state.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_value_in  = out_value_ff;
      out_status_in = out_status_ff;
      res_value_in  = res_value_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_step_in   = div_step_ff;
      div_neg_in    = div_neg_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               out_value_in  = '0;
               out_status_in = STATUS_OK;
               unique case (mode)
                  MODE_PUSH: begin
                     out_valid_in = 1'b1;
                     if (is_full) begin
                        out_status_in = STATUS_FULL;
                     end else begin
                        tail_in  = (tail_ff == LAST_IDX) ? '0 : tail_ff + 1'b1;
                        count_in = count_ff + 1'b1;
                        sum_in   = sum_ff + {{IDX_W{req_value[DATA_W-1]}}, req_value};
                     end
                  end
                  MODE_POP: begin
                     if (is_empty) begin
                        out_valid_in  = 1'b1;
                        out_value_in  = EMPTY_VALUE;
                        out_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_POP;
                     end
                  end
                  MODE_QUERY: begin
                     if (is_empty) begin
                        out_valid_in  = 1'b1;
                        out_value_in  = EMPTY_VALUE;
                        out_status_in = STATUS_EMPTY;
                     end else begin
                        div_neg_in  = sum_ff[SUM_W-1];
                        div_num_in  = sum_ff[SUM_W-1] ? (SUM_W'(0) - sum_ff) : sum_ff;
                        div_rem_in  = '0;
                        div_step_in = LAST_STEP;
                        state_in    = ST_DIV;
                     end
                  end
                  MODE_NOP: begin
                     out_valid_in = 1'b1;
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_POP: begin
            // Read data for the head entry has arrived from the memory.
            res_value_in = ram_rd_data;
            head_in      = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
            count_in     = count_ff - 1'b1;
            sum_in       = sum_ff - {{IDX_W{ram_rd_data[DATA_W-1]}}, ram_rd_data};
            state_in     = ST_RESP;
         end
         ST_DIV: begin
            div_rem_in = rem_ge ? CNT_W'(rem_shift - {1'b0, count_ff})
                                : rem_shift[CNT_W-1:0];
            div_num_in = {div_num_ff[SUM_W-2:0], rem_ge};
            if (div_step_ff == '0) begin
               state_in = ST_RESP;
            end else begin
               div_step_in = div_step_ff - 1'b1;
            end
         end
         ST_RESP: begin
            // A finished division leaves its quotient magnitude in the dividend register.
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = STATUS_OK;
               out_value_in  = (div_step_ff == '0) ? quot_signed[DATA_W-1:0]
                                                   : res_value_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Pop responses must not pick up a stale quotient, so the step counter marks queries.
   // It stays nonzero after a pop because ST_POP sets it below.
   logic [STEP_W-1:0] div_step_sel;
   assign div_step_sel = (state_ff == ST_POP) ? LAST_STEP : div_step_in;

   // State, queue control and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
         div_step_ff  <= LAST_STEP;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
         div_step_ff  <= div_step_sel;
      end
      out_value_ff  <= out_value_in;
      out_status_ff <= out_status_in;
      res_value_ff  <= res_value_in;
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      div_neg_ff    <= div_neg_in;
   end

   // The item count never exceeds the capacity.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("item count above capacity");

   // An empty or a full queue has its head and tail at the same entry.
   a_ends_meet: assert property (@(posedge clock) disable iff (reset)
      (is_empty || is_full) |-> (head_ff == tail_ff))
      else $error("head and tail disagree with item count");

   // The divider never runs with a zero divisor.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !is_empty)
      else $error("division by an empty count");

   // A pop read cycle always follows an accepted pop on a non-empty queue.
   a_pop_follows: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |=> (state_ff == ST_POP))
      else $error("pop read data not consumed");

endmodule

@@ sim/fifo_running_average_top_tb.sv @@
`timescale 1ns / 1ps

module fifo_running_average_top_tb;
   import fra_pkg::*;

   localparam int unsigned QUEUE_DEPTH    = 256;
   localparam int          HOLD_CYCLES    = 200;
   localparam int          SETTLE_CYCLES  = 60;
   localparam int          WATCHDOG_LIMIT = 5000;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      status_type               status;
   } result_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_mode = MODE_NOP;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_result_value;
   logic [1:0]               rsp_status;

   // Own copy of the queue contents and running sum, kept in step with accepted beats.
   logic signed [DATA_W-1:0] stored_values[$];
   longint                   stored_sum = 0;
   result_beat_type          pending_results[$];
   result_beat_type          due_beat;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic holding = 1'b0;
   event hold_trigger;

   int errors = 0;
   int beats_checked = 0;
   int quiet_cycles = 0;
   int pushes_sent = 0;
   int pops_sent = 0;
   int queries_sent = 0;
   int nops_sent = 0;
   int full_drops = 0;
   int empty_answers = 0;

   fifo_running_average_top #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value),
      .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Work out the answer to one accepted request and update the queue copy.
   function automatic void predict_fifo_result(mode_type op, logic signed [DATA_W-1:0] val);
      result_beat_type          beat;
      logic signed [DATA_W-1:0] oldest;
      longint                   mean;
      beat.value  = '0;
      beat.status = STATUS_OK;
      case (op)
         MODE_PUSH: begin
            pushes_sent++;
            if (stored_values.size() >= QUEUE_DEPTH) begin
               beat.status = STATUS_FULL;
               full_drops++;
            end else begin
               stored_values.push_back(val);
               stored_sum += val;
            end
         end
         MODE_POP: begin
            pops_sent++;
            if (stored_values.size() == 0) begin
               beat.value  = EMPTY_VALUE;
               beat.status = STATUS_EMPTY;
               empty_answers++;
            end else begin
               oldest = stored_values.pop_front();
               stored_sum -= oldest;
               beat.value = oldest;
            end
         end
         MODE_QUERY: begin
            queries_sent++;
            if (stored_values.size() == 0) begin
               beat.value  = EMPTY_VALUE;
               beat.status = STATUS_EMPTY;
               empty_answers++;
            end else begin
               // Signed division truncates toward zero.
               mean = stored_sum / longint'(stored_values.size());
               beat.value = mean[DATA_W-1:0];
            end
         end
         default: begin
            nops_sent++;
         end
      endcase
      pending_results.push_back(beat);
   endfunction

   function automatic mode_type pick_mode();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45) return MODE_PUSH;
      if (roll < 75) return MODE_POP;
      if (roll < 95) return MODE_QUERY;
      return MODE_NOP;
   endfunction

   // Values lean towards the extremes and small numbers that exercise truncation.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return -1;
         3: return 0;
         4: return int'($urandom_range(200)) - 100;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request beat, with random idle cycles ahead of it, and hold it until taken.
   task automatic send_beat(input mode_type op, input logic signed [DATA_W-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= op;
      req_value <= val;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_fifo_result(op, val);
   endtask

   // Empty answers, the unused mode, extreme values and rounding toward zero.
   task automatic test_directed_corners();
      send_beat(MODE_POP, 0);
      send_beat(MODE_QUERY, VALUE_MAX);
      send_beat(MODE_NOP, VALUE_MAX);
      send_beat(MODE_PUSH, VALUE_MAX);
      send_beat(MODE_QUERY, 0);
      send_beat(MODE_PUSH, VALUE_MIN);
      send_beat(MODE_QUERY, 0);
      send_beat(MODE_POP, VALUE_MIN);
      send_beat(MODE_QUERY, 0);
      send_beat(MODE_POP, 0);
      send_beat(MODE_POP, 0);
      send_beat(MODE_PUSH, -7);
      send_beat(MODE_PUSH, 2);
      send_beat(MODE_QUERY, 0);
      send_beat(MODE_PUSH, 0);
      send_beat(MODE_QUERY, -1);
      send_beat(MODE_NOP, VALUE_MIN);
      send_beat(MODE_PUSH, -1);
      send_beat(MODE_POP, 0);
      send_beat(MODE_POP, 0);
      send_beat(MODE_POP, 0);
      send_beat(MODE_POP, 0);
      send_beat(MODE_QUERY, 0);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_receiver_hold();
      @(negedge clock);
      req_valid <= 1'b0;
      -> hold_trigger;
      repeat (4) begin
         send_beat(MODE_PUSH, pick_value());
         send_beat(MODE_QUERY, pick_value());
      end
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_beat(pick_mode(), pick_value());
   endtask

   // Fill to capacity with the most negative value, overflow, mix in the maximum so
   // that both indices wrap, then drain back to empty with queries along the way.
   task automatic test_fill_and_wrap();
      int drained;
      drained = 0;
      while (stored_values.size() < QUEUE_DEPTH) send_beat(MODE_PUSH, VALUE_MIN);
      send_beat(MODE_QUERY, 0);
      send_beat(MODE_PUSH, VALUE_MAX);
      send_beat(MODE_PUSH, 5);
      repeat (8) send_beat(MODE_POP, 0);
      repeat (8) send_beat(MODE_PUSH, VALUE_MAX);
      send_beat(MODE_QUERY, 0);
      send_beat(MODE_PUSH, 1);
      while (stored_values.size() > 0) begin
         send_beat(MODE_POP, 0);
         drained++;
         if (drained % 32 == 0) send_beat(MODE_QUERY, 0);
      end
      send_beat(MODE_POP, 0);
      send_beat(MODE_QUERY, 0);
   endtask

   // Receiver stall: random, forced high while a hold-off is running.
   always @(negedge clock) begin
      rsp_stall <= holding || ($urandom_range(99) < recv_idle_pct);
   end

   // The hold-off length is counted here, apart from the sender.
   initial begin
      forever begin
         @(hold_trigger);
         holding = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding = 1'b0;
      end
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with nothing expected: value %0d status %0d",
                     $time, rsp_result_value, rsp_status);
            errors++;
         end else begin
            due_beat = pending_results.pop_front();
            beats_checked++;
            if (rsp_result_value !== due_beat.value) begin
               $display("%0t: result value mismatch: expected %0d, got %0d",
                        $time, due_beat.value, rsp_result_value);
               errors++;
            end
            if (rsp_status !== due_beat.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, due_beat.status, rsp_status);
               errors++;
            end
         end
      end
   end

   // Watchdog: give up when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
         $display("fifo_running_average_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender seldom idle, receiver often stalled.
      send_idle_pct = 11;
      recv_idle_pct = 76;
      test_directed_corners();
      test_receiver_hold();
      test_random_traffic(20);

      // Sender often idle, receiver seldom stalled.
      send_idle_pct = 76;
      recv_idle_pct = 11;
      test_random_traffic(20);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(20);
      test_fill_and_wrap();

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d pushes (%0d dropped), %0d pops, %0d queries, %0d unused-mode beats.",
               pushes_sent, full_drops, pops_sent, queries_sent, nops_sent);
      $display("Checked %0d result beats, %0d of them empty answers; %0d errors.",
               beats_checked, empty_answers, errors);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("fifo_running_average_top test passed");
      end else begin
         $display("fifo_running_average_top test failed");
      end
      $finish;
   end

endmodule
